FILE: rtl/hmc_pkg.sv
// Shared types and constants for the hashed memo cache.
package hmc_pkg;

  localparam int unsigned KEY_W      = 48;
  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned SLOT_W     = 15;
  localparam int unsigned HASH_SHIFT = 15;

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_SET    = 1'b1
  } func_t;

  typedef struct packed {
    func_t               func;
    logic [KEY_W-1:0]    key_first;
    logic [KEY_W-1:0]    key_second;
    logic [KEY_W-1:0]    key_third;
    logic [PHASE_W-1:0]  key_phase;
    logic [SLOT_W-1:0]   set_index;
    logic                set_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               cached_value;
    logic [SLOT_W-1:0]  slot_index;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]    first;
    logic [KEY_W-1:0]    second;
    logic [KEY_W-1:0]    third;
    logic [PHASE_W-1:0]  phase;
  } tag_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_ACCESS
  } back_state_t;

endpackage

FILE: rtl/hashed_memo_cache_unit.sv
// Top level of the hashed memo cache: front end, queue, back end, enable register.
// An accepted item passes the queue and the hash, read and access steps of the back end.
// The back end takes the next item only after the access step has emitted the last one.
// Up to two items wait in the queue while the back end or the result side stalls.
// Reset: synchronous; afterwards the tables are cleared one entry a cycle, with full
// held high until the last entry is cleared; cache_enable resets to 1.
module hashed_memo_cache_unit #(
  parameter int unsigned TABLE_DEPTH = 32768
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  hmc_pkg::req_t         request,
  output logic                  empty,
  input  logic                  pop,
  output hmc_pkg::rsp_t         response,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned SUM_W  = IDX_W + hmc_pkg::HASH_SHIFT;
  localparam int unsigned DATA_W = $bits(hmc_pkg::req_t) + SUM_W;

  logic              cache_enable;
  logic              clearing;
  logic              q_full;
  logic              q_push;
  logic [DATA_W-1:0] q_wdata;
  logic              q_valid;
  logic              q_pop;
  logic [DATA_W-1:0] q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      cache_enable <= cfg_data;
    end
  end

  hmc_front #(
    .SUM_W (SUM_W)
  ) u_front (
    .push     (push),
    .full     (full),
    .request  (request),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  hmc_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wdata),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rdata)
  );

  hmc_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SUM_W       (SUM_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .enable   (cache_enable),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .response (response)
  );

endmodule

FILE: rtl/hmc_front.sv
// Front end: accepts items and forms the weighted key sum for the hash.
module hmc_front #(
  parameter int unsigned SUM_W = 30
) (
  input  logic                   push,
  output logic                   full,
  input  hmc_pkg::req_t          request,
  input  logic                   clearing,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [$bits(hmc_pkg::req_t)+SUM_W-1:0] q_data
);

  logic [SUM_W-1:0] sum;

  // a + 17b + 257c + 513d, kept to the bits the index needs
  assign sum = SUM_W'(request.key_first)
             + SUM_W'({request.key_second, 4'b0000}) + SUM_W'(request.key_second)
             + SUM_W'({request.key_third, 8'h00}) + SUM_W'(request.key_third)
             + SUM_W'({request.key_phase, 9'h000}) + SUM_W'(request.key_phase);

  assign full   = q_full || clearing;
  assign q_push = push && !full;
  assign q_data = {request, sum};

endmodule

FILE: rtl/hmc_queue.sv
// Two-entry queue between the front and back ends.
module hmc_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              q_full,
  input  logic              rd_en,
  output logic              rd_valid,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  assign q_full   = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_ptr];

endmodule

FILE: rtl/hmc_back.sv
// Back end: finishes the hash, accesses the tables and holds the result item.
module hmc_back #(
  parameter int unsigned TABLE_DEPTH = 32768,
  parameter int unsigned SUM_W       = 30
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   enable,
  output logic                   clearing,
  input  logic                   q_valid,
  input  logic [$bits(hmc_pkg::req_t)+SUM_W-1:0] q_data,
  output logic                   q_pop,
  output logic                   empty,
  input  logic                   pop,
  output hmc_pkg::rsp_t          response
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned TAG_W = $bits(hmc_pkg::tag_t);

  hmc_pkg::back_state_t state, state_next;

  hmc_pkg::req_t    cur;
  logic [SUM_W-1:0] cur_sum;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] clr_addr;
  logic             clr_last;

  logic [TAG_W-1:0] tag_mem [TABLE_DEPTH];
  logic             res_mem [TABLE_DEPTH];
  hmc_pkg::tag_t    tag_rd;
  logic             res_rd;

  hmc_pkg::tag_t    key;
  logic             is_set;
  logic             match;
  logic             emit;
  logic             rd_en;
  logic             tag_we;
  logic [IDX_W-1:0] tag_wa;
  logic [TAG_W-1:0] tag_wd;
  logic             res_we;
  logic [IDX_W-1:0] res_wa;
  logic             res_wd;
  hmc_pkg::rsp_t    rsp_next;
  logic             out_valid;

  assign clr_last = (clr_addr == IDX_W'(TABLE_DEPTH - 1));
  assign is_set   = (cur.func == hmc_pkg::FUNC_SET);
  assign key      = '{first: cur.key_first, second: cur.key_second,
                      third: cur.key_third, phase: cur.key_phase};
  assign match    = (tag_rd == key);

  always_comb begin
    state_next = state;
    unique case (state)
      hmc_pkg::ST_CLEAR:  state_next = clr_last ? hmc_pkg::ST_IDLE : hmc_pkg::ST_CLEAR;
      hmc_pkg::ST_IDLE:   state_next = q_valid ? hmc_pkg::ST_HASH : hmc_pkg::ST_IDLE;
      hmc_pkg::ST_HASH:   state_next = hmc_pkg::ST_READ;
      hmc_pkg::ST_READ:   state_next = hmc_pkg::ST_ACCESS;
      hmc_pkg::ST_ACCESS: begin
        if (!out_valid || pop) begin
          state_next = q_valid ? hmc_pkg::ST_HASH : hmc_pkg::ST_IDLE;
        end
      end
      default:            state_next = hmc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing = (state == hmc_pkg::ST_CLEAR);
    emit     = (state == hmc_pkg::ST_ACCESS) && (!out_valid || pop);
    rd_en    = (state == hmc_pkg::ST_READ);
    q_pop    = q_valid && ((state == hmc_pkg::ST_IDLE) || emit);
    tag_we   = clearing || (emit && !is_set && enable && !match);
    tag_wa   = clearing ? clr_addr : idx;
    tag_wd   = clearing ? '0 : key;
    res_we   = clearing || (emit && is_set && enable);
    res_wa   = clearing ? clr_addr : IDX_W'(cur.set_index);
    res_wd   = clearing ? 1'b0 : cur.set_value;
  end

  always_comb begin
    rsp_next = '0;
    priority if (is_set) begin
      rsp_next.slot_index = cur.set_index;
    end else if (!enable) begin
      rsp_next = '0;
    end else if (match) begin
      rsp_next.hit          = 1'b1;
      rsp_next.cached_value = res_rd;
    end else begin
      rsp_next.slot_index = hmc_pkg::SLOT_W'(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hmc_pkg::ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= hmc_pkg::req_t'(q_data[$bits(hmc_pkg::req_t)+SUM_W-1:SUM_W]);
      cur_sum <= q_data[SUM_W-1:0];
    end
    if (state == hmc_pkg::ST_HASH) begin
      // h + (h >> 15), masked to the table
      idx <= cur_sum[IDX_W-1:0] + cur_sum[IDX_W+hmc_pkg::HASH_SHIFT-1:hmc_pkg::HASH_SHIFT];
    end
    if (emit) begin
      response <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (rd_en) begin
      tag_rd <= hmc_pkg::tag_t'(tag_mem[idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_wa] <= res_wd;
    end
    if (rd_en) begin
      res_rd <= res_mem[idx];
    end
  end

  assign empty = !out_valid;

endmodule

FILE: rtl/hmc_checker.sv
// Port-level checks for the hashed memo cache, bound to the top level.
module hmc_port_checks (
  input logic          clk,
  input logic          rst,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input hmc_pkg::rsp_t response
);

  // table clear runs after reset, so no item can be taken
  a_full_after_rst: assert property (@(posedge clk) rst |=> full)
    else $error("full not raised after reset");

  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(response)))
    else $error("waiting result item changed");

  a_hit_slot: assert property (@(posedge clk) disable iff (rst)
    (!empty && response.hit) |-> (response.slot_index == '0))
    else $error("hit with nonzero slot index");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (!empty && !response.hit) |-> !response.cached_value)
    else $error("cached value without hit");

endmodule

bind hashed_memo_cache_unit hmc_port_checks u_hmc_port_checks (.*);
